>>> rtl/core/sbt_pkg.sv
// Shared types, codes and defaults for the sparse bitmap table engine.
// No dependencies; the front end, back end, top level and testbench import this package.
package sbt_pkg;

    // Default sizes
    localparam int GROUP_SIZE_DEF  = 64;
    localparam int GROUP_COUNT_DEF = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    // Command codes as they arrive on the input channel
    localparam logic [2:0] CMD_FIND    = 3'd0;
    localparam logic [2:0] CMD_INSERT  = 3'd1;
    localparam logic [2:0] CMD_REPLACE = 3'd2;
    localparam logic [2:0] CMD_ERASE   = 3'd3;
    localparam logic [2:0] CMD_NEXT    = 3'd4;
    localparam logic [2:0] CMD_CLEAR   = 3'd5;

    // Result status codes
    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_EMPTY    = 3'd1;
    localparam logic [2:0] STAT_OCCUPIED = 3'd2;
    localparam logic [2:0] STAT_RANGE    = 3'd3;
    localparam logic [2:0] STAT_END      = 3'd4;

    // Decoded operation
    typedef enum logic [2:0] {
        OP_FIND,
        OP_INSERT,
        OP_REPLACE,
        OP_ERASE,
        OP_NEXT,
        OP_CLEAR,
        OP_NOP
    } op_e_t;

    // One classified item, as queued between front and back
    typedef struct packed {
        op_e_t       op;
        logic [9:0]  index;
        logic        start;
        logic [31:0] data;
    } item_t;

    // Back-end sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RD,
        ST_RDWAIT,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_COMMIT,
        ST_OUT
    } state_e_t;

    // Queue handshake toward the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_out_t;

endpackage

>>> rtl/core/sbt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sbt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/sbt_front.sv
// Front end: accepts input items, decodes the command and queues up to two items.
// Depends on sbt_pkg.
module sbt_front
    import sbt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_cmd,
    input  logic [9:0]  s_index,
    input  logic        s_start,
    input  logic [31:0] s_data,
    output queue_out_t  q_out,
    input  logic        q_pop
);

    item_t      fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    item_t      item_in;

    // Classify the command
    always_comb begin
        item_in.index = s_index;
        item_in.start = s_start;
        item_in.data  = s_data;
        unique case (s_cmd)
            CMD_FIND:    item_in.op = OP_FIND;
            CMD_INSERT:  item_in.op = OP_INSERT;
            CMD_REPLACE: item_in.op = OP_REPLACE;
            CMD_ERASE:   item_in.op = OP_ERASE;
            CMD_NEXT:    item_in.op = OP_NEXT;
            CMD_CLEAR:   item_in.op = OP_CLEAR;
            default:     item_in.op = OP_NOP;
        endcase
    end

    assign s_tready    = (count_reg != 2'd2);
    assign push        = s_tvalid && s_tready;
    assign q_out.valid = (count_reg != 2'd0);
    assign q_out.item  = fifo_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold queued payload
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

>>> rtl/core/sbt_back.sv
// Back end: bitmaps, group counts and the sequencer that runs each command
// against the packed value RAM. Depends on sbt_pkg and sbt_ram.
module sbt_back
    import sbt_pkg::*;
#(
    parameter int GROUP_SIZE  = GROUP_SIZE_DEF,
    parameter int GROUP_COUNT = GROUP_COUNT_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [10:0] slot_limit,
    input  queue_out_t  q_in,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [2:0]  m_status,
    output logic        m_present,
    output logic        m_deleted,
    output logic [31:0] m_value,
    output logic [10:0] m_found,
    output logic [6:0]  m_rank,
    output logic [10:0] m_total
);

    localparam int CAP = GROUP_COUNT * GROUP_SIZE;
    localparam int AW  = $clog2(CAP);
    localparam int PW  = $clog2(GROUP_SIZE);
    localparam int GW  = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int CW  = $clog2(GROUP_SIZE + 1);
    localparam int TW  = $clog2(CAP + 1);
    localparam int SW  = (AW + 1 > 11) ? AW + 1 : 11;

    state_e_t state_reg, state_next;

    logic [GROUP_SIZE-1:0] occ_reg [GROUP_COUNT];
    logic [GROUP_SIZE-1:0] del_reg [GROUP_COUNT];
    logic [CW-1:0]         cnt_reg [GROUP_COUNT];
    logic [TW-1:0]         total_reg;

    op_e_t            op_reg;
    logic [VALUE_WIDTH-1:0] dv_reg;
    logic [SW-1:0]    tgt_reg;
    logic [SW-1:0]    j_reg;
    logic [CW-1:0]    rank_reg;
    logic [CW-1:0]    k_reg;

    logic [2:0]       st_res_reg;
    logic             pres_res_reg;
    logic             del_res_reg;
    logic [VALUE_WIDTH-1:0] rv_res_reg;
    logic [10:0]      fi_res_reg;
    logic [CW-1:0]    rk_res_reg;

    logic [SW-1:0]    size_w;
    logic [GW-1:0]    g_w;
    logic [PW-1:0]    p_w;
    logic             occ_bit, del_bit;
    logic [CW-1:0]    cnt_w;
    logic [SW-1:0]    base_w;
    logic             oor_w, hit_w, more_w, is_ins;
    logic [SW-1:0]    idx_w, tgt_in;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_wdata, ram_rdata;

    // Address decode of the current scan slot
    assign size_w  = (SW'(slot_limit) > SW'(CAP)) ? SW'(CAP) : SW'(slot_limit);
    assign g_w     = GW'(j_reg >> PW);
    assign p_w     = PW'(j_reg);
    assign occ_bit = occ_reg[g_w][p_w];
    assign del_bit = del_reg[g_w][p_w];
    assign cnt_w   = cnt_reg[g_w];
    assign base_w  = (j_reg >> PW) << PW;
    assign hit_w   = (j_reg == tgt_reg);
    assign is_ins  = (op_reg == OP_INSERT);
    assign more_w  = is_ins ? (k_reg > rank_reg)
                            : ((CW + 1)'(k_reg) + (CW + 1)'(1) < (CW + 1)'(cnt_w));

    // Classify the item at the queue head
    assign idx_w  = SW'(q_in.item.index);
    assign oor_w  = (q_in.item.op == OP_NEXT) ? (!q_in.item.start && idx_w >= size_w)
                  : ((q_in.item.op != OP_CLEAR) && (q_in.item.op != OP_NOP)
                     && idx_w >= size_w);
    assign tgt_in = (q_in.item.op != OP_NEXT) ? idx_w
                  : (q_in.item.start ? '0 : idx_w + SW'(1));

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_in.valid) begin
                    if (oor_w || q_in.item.op == OP_CLEAR || q_in.item.op == OP_NOP)
                        state_next = ST_OUT;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (op_reg == OP_NEXT) begin
                    if (j_reg >= size_w)
                        state_next = ST_OUT;
                    else if (j_reg >= tgt_reg && occ_bit)
                        state_next = ST_RD;
                end else if (hit_w) begin
                    if (occ_bit)
                        state_next = ST_RD;
                    else if (is_ins)
                        state_next = ST_SHIFT_RD;
                    else
                        state_next = ST_OUT;
                end
            end
            ST_RD:       state_next = ST_RDWAIT;
            ST_RDWAIT:   state_next = (op_reg == OP_ERASE) ? ST_SHIFT_RD : ST_OUT;
            ST_SHIFT_RD: state_next = more_w ? ST_SHIFT_WR : ST_COMMIT;
            ST_SHIFT_WR: state_next = ST_SHIFT_RD;
            ST_COMMIT:   state_next = ST_OUT;
            ST_OUT:      state_next = m_tready ? ST_IDLE : ST_OUT;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Outputs: queue pop, RAM controls, result valid
    always_comb begin
        q_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = AW'(base_w + SW'(rank_reg));
        ram_wdata = dv_reg;
        ram_raddr = AW'(base_w + SW'(rank_reg));
        m_tvalid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:     q_pop = q_in.valid;
            ST_RDWAIT:   ram_we = (op_reg == OP_REPLACE);
            ST_SHIFT_RD: begin
                ram_raddr = is_ins ? AW'(base_w + SW'(k_reg) - SW'(1))
                                   : AW'(base_w + SW'(k_reg) + SW'(1));
            end
            ST_SHIFT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(base_w + SW'(k_reg));
                ram_wdata = ram_rdata;
            end
            ST_COMMIT:   ram_we = is_ins;
            ST_OUT:      m_tvalid = 1'b1;
            default:     ;
        endcase
    end

    // Sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // Bitmaps, counts and total
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < GROUP_COUNT; i++) begin
                occ_reg[i] <= '0;
                del_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
            total_reg <= '0;
        end else if (state_reg == ST_IDLE && q_in.valid && q_in.item.op == OP_CLEAR) begin
            for (int i = 0; i < GROUP_COUNT; i++) begin
                occ_reg[i] <= '0;
                del_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
            total_reg <= '0;
        end else if (state_reg == ST_COMMIT) begin
            if (is_ins) begin
                occ_reg[g_w][p_w] <= 1'b1;
                cnt_reg[g_w]      <= cnt_w + CW'(1);
                total_reg         <= total_reg + TW'(1);
            end else begin
                occ_reg[g_w][p_w] <= 1'b0;
                del_reg[g_w][p_w] <= 1'b1;
                cnt_reg[g_w]      <= cnt_w - CW'(1);
                total_reg         <= total_reg - TW'(1);
            end
        end
    end

    // Working and result registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                op_reg       <= q_in.item.op;
                dv_reg       <= VALUE_WIDTH'(q_in.item.data);
                tgt_reg      <= tgt_in;
                j_reg        <= (tgt_in >> PW) << PW;
                rank_reg     <= '0;
                st_res_reg   <= oor_w ? STAT_RANGE : STAT_OK;
                pres_res_reg <= 1'b0;
                del_res_reg  <= 1'b0;
                rv_res_reg   <= '0;
                fi_res_reg   <= (q_in.item.op == OP_CLEAR) ? 11'd0 : 11'(q_in.item.index);
                rk_res_reg   <= '0;
            end
            ST_SCAN: begin
                if (op_reg == OP_NEXT) begin
                    if (j_reg >= size_w) begin
                        st_res_reg <= STAT_END;
                        fi_res_reg <= 11'(size_w);
                    end else if (j_reg >= tgt_reg && occ_bit) begin
                        pres_res_reg <= 1'b1;
                        fi_res_reg   <= 11'(j_reg);
                        rk_res_reg   <= rank_reg;
                    end else begin
                        rank_reg <= (p_w == PW'(GROUP_SIZE - 1)) ? '0
                                                                : rank_reg + CW'(occ_bit);
                        j_reg    <= j_reg + SW'(1);
                    end
                end else if (hit_w) begin
                    pres_res_reg <= occ_bit;
                    rk_res_reg   <= rank_reg;
                    k_reg        <= cnt_w;
                    if (!occ_bit) begin
                        del_res_reg <= del_bit;
                        st_res_reg  <= is_ins ? STAT_OK : STAT_EMPTY;
                    end
                end else begin
                    rank_reg <= rank_reg + CW'(occ_bit);
                    j_reg    <= j_reg + SW'(1);
                end
            end
            ST_RDWAIT: begin
                rv_res_reg  <= ram_rdata;
                del_res_reg <= del_bit;
                k_reg       <= rank_reg;
                if (is_ins) st_res_reg <= STAT_OCCUPIED;
            end
            ST_SHIFT_WR: begin
                k_reg <= is_ins ? k_reg - CW'(1) : k_reg + CW'(1);
            end
            ST_COMMIT: begin
                if (!is_ins) del_res_reg <= 1'b1;
            end
            default: ;
        endcase
    end

    sbt_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAP)
    ) u_values (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_status  = st_res_reg;
    assign m_present = pres_res_reg;
    assign m_deleted = del_res_reg;
    assign m_value   = 32'(rv_res_reg);
    assign m_found   = fi_res_reg;
    assign m_rank    = 7'(rk_res_reg);
    assign m_total   = 11'(total_reg);

    // The occupied total never exceeds the capacity
    a_total_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        TW'(total_reg) <= TW'(CAP))
        else $error("occupied total above capacity");

    // A popped item always leaves idle
    a_pop_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && q_in.valid) |=> (state_reg != ST_IDLE))
        else $error("item popped but sequencer stayed idle");

    // An insert commits only into a group with room
    a_insert_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMMIT && is_ins) |-> ((CW + 1)'(cnt_w) < (CW + 1)'(GROUP_SIZE)))
        else $error("insert into full group");

    // Shifting stays inside the group's packed range
    a_shift_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT_WR) |-> (k_reg <= cnt_w))
        else $error("shift index beyond group count");

endmodule

>>> rtl/core/sparse_bitmap_table_engine.sv
// Top level of the sparse bitmap table engine: ports, size register, front and back.
// Depends on sbt_pkg, sbt_front, sbt_back (and sbt_ram below it).
//
// Usage: commands enter on the s_ stream (command in s_tuser), one result per
// command leaves on the m_ stream (status in m_tuser). The slot limit is written
// on the cfg_ channel, which is always ready; write it only while idle.
// Two-entry queue decouples input acceptance from execution, and the result
// register holds until m_tready, so a stalled receiver only stops the back end
// while the front keeps taking items until the queue fills.
// Command flow, set by the simple dual-port value RAM and a one-slot-a-cycle
// bitmap scan: find/replace scan from the group start to the slot, then read;
// insert and erase also shift the packed values above the slot (fewer than GROUP_SIZE);
// next scans one slot per cycle up to the table size;
// clear and out-of-range items go straight to the result.
// Execution: one command executes at a time, passing through idle between results.
// Reset: all bitmaps, counts and the total clear at once, the slot limit returns
// to 1024; stored values are undefined until written.
module sparse_bitmap_table_engine
    import sbt_pkg::*;
#(
    parameter int GROUP_SIZE  = GROUP_SIZE_DEF,
    parameter int GROUP_COUNT = GROUP_COUNT_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // index[9:0], start_flag[10], data_value[42:11], zero
    input  logic [2:0]  s_tuser,   // command[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // present[0], ever_deleted[1], read_value[33:2],
                                   // found_index[44:34], rank_in_group[51:45],
                                   // total_count[62:52], zero
    output logic [2:0]  m_tuser,   // status[2:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data   // slot limit
);

    logic [10:0] size_reg;
    queue_out_t  q;
    logic        q_pop;
    logic        present, deleted;
    logic [31:0] value;
    logic [10:0] found, total;
    logic [6:0]  rank;

    // Hold the table size register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn)       size_reg <= 11'd1024;
        else if (cfg_valid) size_reg <= cfg_data;
    end

    sbt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser),
        .s_index  (s_tdata[9:0]),
        .s_start  (s_tdata[10]),
        .s_data   (s_tdata[42:11]),
        .q_out    (q),
        .q_pop    (q_pop)
    );

    sbt_back #(
        .GROUP_SIZE  (GROUP_SIZE),
        .GROUP_COUNT (GROUP_COUNT),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .slot_limit (size_reg),
        .q_in       (q),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_status   (m_tuser),
        .m_present  (present),
        .m_deleted  (deleted),
        .m_value    (value),
        .m_found    (found),
        .m_rank     (rank),
        .m_total    (total)
    );

    // Pack the result fields
    assign m_tdata = {1'b0, total, rank, found, value, deleted, present};

endmodule

>>> test/sparse_bitmap_table_engine_tb.sv
// Self-checking testbench for the sparse bitmap table engine: directed table, then random items.
// Depends on sbt_pkg and the sparse_bitmap_table_engine RTL; results checked by a local table model.
module sparse_bitmap_table_engine_tb
    import sbt_pkg::*;
();

    localparam int GSZ = 64;
    localparam int NGRP = 16;
    localparam int CAP = GSZ * NGRP;
    localparam int LIMIT_CYCLES = 3000000;

    // Command codes with no operation behind them
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [2:0]  status;
        logic        present;
        logic        deleted;
        logic [31:0] value;
        logic [10:0] found;
        logic [6:0]  rank;
        logic [10:0] total;
    } table_result_t;

    typedef struct {
        logic [2:0]  cmd;
        logic [9:0]  index;
        logic        start;
        logic [31:0] data;
        logic        fixed;
        logic [2:0]  status;
        logic [10:0] found;
        logic [10:0] total;
    } directed_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [10:0] cfg_data = '0;

    // Table mirror
    logic [GSZ-1:0] occ_map [NGRP];
    logic [GSZ-1:0] del_map [NGRP];
    logic [31:0]    slot_vals [CAP];
    logic [10:0]    occ_total;
    logic [10:0]    size_reg;

    table_result_t pending_results[$];
    logic          pending_fixed[$];
    int            errors = 0;
    int            results_seen = 0;
    int            cycles = 0;
    int            recv_mode = 0;
    int            hold_off = 0;
    int            hold_len = 0;
    logic          hold_used = 1'b0;
    int            send_idle_pct = 0;

    sparse_bitmap_table_engine u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #6 aclk = ~aclk;

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("%0t timeout, %0d results pending", $time, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int count_below(int g, int p);
        int n;
        n = 0;
        for (int k = 0; k < p; k++) n += occ_map[g][k];
        return n;
    endfunction

    // Compute expected result and update the mirror
    function automatic table_result_t table_step(logic [2:0] cmd, logic [9:0] idx,
                                                 logic st, logic [31:0] dv);
        table_result_t r;
        int lim, g, p, b, cnt, j;
        r = '0;
        r.found = 11'(idx);
        lim = (size_reg > CAP) ? CAP : size_reg;
        if (cmd <= CMD_ERASE) begin
            if (idx >= lim) begin
                r.status = STAT_RANGE;
            end else begin
                g = idx / GSZ; p = idx % GSZ; b = g * GSZ;
                cnt = count_below(g, GSZ);
                r.rank = 7'(count_below(g, p));
                r.present = occ_map[g][p];
                r.value = r.present ? slot_vals[b + r.rank] : 32'd0;
                case (cmd)
                    CMD_FIND: r.status = r.present ? STAT_OK : STAT_EMPTY;
                    CMD_INSERT: begin
                        if (r.present) begin
                            r.status = STAT_OCCUPIED;
                        end else begin
                            for (int k = cnt; k > r.rank; k--) slot_vals[b+k] = slot_vals[b+k-1];
                            slot_vals[b + r.rank] = dv;
                            occ_map[g][p] = 1'b1;
                            occ_total++;
                        end
                    end
                    CMD_REPLACE: begin
                        if (!r.present) r.status = STAT_EMPTY;
                        else slot_vals[b + r.rank] = dv;
                    end
                    default: begin
                        if (!r.present) begin
                            r.status = STAT_EMPTY;
                        end else begin
                            for (int k = r.rank; k + 1 < cnt; k++) slot_vals[b+k] = slot_vals[b+k+1];
                            occ_map[g][p] = 1'b0;
                            del_map[g][p] = 1'b1;
                            occ_total--;
                        end
                    end
                endcase
                r.deleted = del_map[g][p];
            end
        end else if (cmd == CMD_NEXT) begin
            if (!st && idx >= lim) begin
                r.status = STAT_RANGE;
            end else begin
                r.status = STAT_END;
                r.found = 11'(lim);
                for (j = st ? 0 : idx + 1; j < lim; j++) begin
                    g = j / GSZ; p = j % GSZ;
                    if (occ_map[g][p]) begin
                        r.status = STAT_OK;
                        r.found = 11'(j);
                        r.present = 1'b1;
                        r.rank = 7'(count_below(g, p));
                        r.value = slot_vals[g * GSZ + r.rank];
                        r.deleted = del_map[g][p];
                        break;
                    end
                end
            end
        end else if (cmd == CMD_CLEAR) begin
            for (int k = 0; k < NGRP; k++) begin
                occ_map[k] = '0;
                del_map[k] = '0;
            end
            occ_total = '0;
            r.found = '0;
        end
        r.total = occ_total;
        return r;
    endfunction

    // Send one item and queue its expectation; valid stays up after acceptance
    task automatic send_item(logic [2:0] cmd, logic [9:0] idx, logic st, logic [31:0] dv);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        pending_results.push_back(table_step(cmd, idx, st, dv));
        pending_fixed.push_back(1'b0);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'd0, dv, st, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_size(logic [10:0] sz);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= sz;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        size_reg = sz;
    endtask

    // Receiver: random stalls, plus one long hold-off when requested
    always @(posedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else if (hold_len > 0 && !hold_used) begin
            hold_off  <= hold_len - 1;
            hold_used <= 1'b1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= (recv_mode == 0) ? 1'b1 : ($urandom_range(99) >= recv_mode);
        end
    end

    // Result checker
    always @(posedge aclk) begin
        table_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '0;
            got.status  = m_tuser;
            got.present = m_tdata[0];
            got.deleted = m_tdata[1];
            got.value   = m_tdata[33:2];
            got.found   = m_tdata[44:34];
            got.rank    = m_tdata[51:45];
            got.total   = m_tdata[62:52];
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result: actual %h", $time, got);
                errors++;
            end else begin
                want = pending_results.pop_front();
                void'(pending_fixed.pop_front());
                if (got !== want) begin
                    $display("%0t mismatch: expected st=%0d p=%0d d=%0d v=%h f=%0d r=%0d t=%0d",
                             $time, want.status, want.present, want.deleted, want.value,
                             want.found, want.rank, want.total);
                    $display("%0t           actual st=%0d p=%0d d=%0d v=%h f=%0d r=%0d t=%0d",
                             $time, got.status, got.present, got.deleted, got.value,
                             got.found, got.rank, got.total);
                    errors++;
                end
            end
        end
    end

    directed_row_t dir_rows[$];

    task automatic add_row(logic [2:0] c, logic [9:0] i, logic s, logic [31:0] d,
                           logic fx, logic [2:0] st, logic [10:0] f, logic [10:0] t);
        directed_row_t row;
        row = '{c, i, s, d, fx, st, f, t};
        dir_rows.push_back(row);
    endtask

    // Random index biased toward the live range and group edges
    function automatic logic [9:0] pick_index(int lim);
        int m;
        m = (lim == 0) ? 1 : lim;
        case ($urandom_range(9))
            0: return 10'($urandom);
            1: return 10'(($urandom_range(NGRP - 1) * GSZ) + ($urandom_range(1) ? GSZ - 1 : 0));
            default: return 10'($urandom_range(m - 1) % CAP);
        endcase
    endfunction

    task automatic random_phase(int n, int ipct, int rmode);
        int lim, sel;
        logic [2:0] c;
        send_idle_pct = ipct;
        recv_mode = rmode;
        for (int i = 0; i < n; i++) begin
            lim = (size_reg > CAP) ? CAP : size_reg;
            sel = $urandom_range(99);
            if (sel < 35) c = CMD_INSERT;
            else if (sel < 55) c = CMD_FIND;
            else if (sel < 68) c = CMD_ERASE;
            else if (sel < 80) c = CMD_REPLACE;
            else if (sel < 90) c = CMD_NEXT;
            else if (sel < 92) c = CMD_CLEAR;
            else c = 3'($urandom_range(7));
            send_item(c, pick_index(lim), 1'($urandom_range(1)), $urandom);
        end
        drain();
    endtask

    initial begin
        table_result_t want;
        directed_row_t row;
        for (int k = 0; k < NGRP; k++) begin
            occ_map[k] = '0;
            del_map[k] = '0;
        end
        for (int k = 0; k < CAP; k++) slot_vals[k] = '0;
        occ_total = '0;
        size_reg = 11'd1024;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows: fixed expectations only for obvious cases
        add_row(CMD_FIND,     10'd0,    1'b0, 32'h0,        1'b1, STAT_EMPTY,    11'd0,    11'd0);
        add_row(CMD_NEXT,     10'd0,    1'b1, 32'h0,        1'b1, STAT_END,      11'd1024, 11'd0);
        add_row(CMD_INSERT,   10'd0,    1'b0, 32'hFFFFFFFF, 1'b1, STAT_OK,       11'd0,    11'd1);
        add_row(CMD_INSERT,   10'd0,    1'b0, 32'h1,        1'b1, STAT_OCCUPIED, 11'd0,    11'd1);
        add_row(CMD_INSERT,   10'd1023, 1'b0, 32'h0,        1'b1, STAT_OK,       11'd1023, 11'd2);
        add_row(CMD_INSERT,   10'd63,   1'b0, 32'hA5A5A5A5, 1'b0, STAT_OK,       11'd0,    11'd0);
        add_row(CMD_INSERT,   10'd62,   1'b0, 32'h5A5A5A5A, 1'b0, STAT_OK,       11'd0,    11'd0);
        add_row(CMD_INSERT,   10'd64,   1'b0, 32'h12345678, 1'b0, STAT_OK,       11'd0,    11'd0);
        add_row(CMD_FIND,     10'd63,   1'b0, 32'h0,        1'b0, STAT_OK,       11'd0,    11'd0);
        add_row(CMD_REPLACE,  10'd62,   1'b0, 32'hDEADBEEF, 1'b0, STAT_OK,       11'd0,    11'd0);
        add_row(CMD_REPLACE,  10'd5,    1'b0, 32'h1,        1'b1, STAT_EMPTY,    11'd5,    11'd5);
        add_row(CMD_ERASE,    10'd7,    1'b0, 32'h0,        1'b1, STAT_EMPTY,    11'd7,    11'd5);
        add_row(CMD_ERASE,    10'd0,    1'b0, 32'h0,        1'b0, STAT_OK,       11'd0,    11'd0);
        add_row(CMD_FIND,     10'd0,    1'b0, 32'h0,        1'b0, STAT_OK,       11'd0,    11'd0);
        add_row(CMD_NEXT,     10'd0,    1'b1, 32'h0,        1'b0, STAT_OK,       11'd0,    11'd0);
        add_row(CMD_NEXT,     10'd63,   1'b0, 32'h0,        1'b0, STAT_OK,       11'd0,    11'd0);
        add_row(CMD_NEXT,     10'd1023, 1'b0, 32'h0,        1'b1, STAT_END,      11'd1024, 11'd4);
        add_row(CMD_SPARE_LO, 10'd9,    1'b1, 32'hFFFFFFFF, 1'b0, STAT_OK,       11'd0,    11'd0);
        add_row(CMD_SPARE_HI, 10'd1023, 1'b0, 32'h0,        1'b0, STAT_OK,       11'd0,    11'd0);
        add_row(CMD_CLEAR,    10'd500,  1'b0, 32'h0,        1'b1, STAT_OK,       11'd0,    11'd0);
        add_row(CMD_FIND,     10'd0,    1'b0, 32'h0,        1'b0, STAT_OK,       11'd0,    11'd0);
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.fixed) begin
                want = table_step(row.cmd, row.index, row.start, row.data);
                if (want.status !== row.status || want.found !== row.found ||
                    want.total !== row.total) begin
                    $display("%0t directed row %0d: expected st=%0d f=%0d t=%0d model %0d/%0d/%0d",
                             $time, i, row.status, row.found, row.total,
                             want.status, want.found, want.total);
                    errors++;
                end
                pending_results.push_back(want);
                pending_fixed.push_back(1'b1);
                s_tvalid <= 1'b1;
                s_tuser  <= row.cmd;
                s_tdata  <= {5'd0, row.data, row.start, row.index};
                @(posedge aclk);
                while (!s_tready) @(posedge aclk);
            end else begin
                send_item(row.cmd, row.index, row.start, row.data);
            end
        end
        drain();

        // Random phases across idling patterns and table sizes
        random_phase(110, 0, 0);
        write_size(11'd100);
        random_phase(80, 70, 0);
        write_size(11'd0);
        random_phase(20, 0, 70);
        write_size(11'd2047);
        random_phase(90, 15, 15);

        // Long receiver hold-off while the sender keeps pushing
        hold_len = 400;
        random_phase(30, 0, 0);
        write_size(11'd1);
        random_phase(30, 0, 70);
        write_size(11'd700);
        random_phase(100, 70, 70);
        write_size(11'd1024);
        random_phase(90, 0, 0);
        drain();
        repeat (50) @(posedge aclk);

        $display("Covered all commands, out-of-range and end-of-table cases, sizes 0..2047,");
        $display("and %0d results under varied idling and back-pressure.", results_seen);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
